// ----- hw/rtl/json_string_unescaper_top_defines.svh -----
// ----------------------------------------------------------------------------
// json_string_unescaper_top_defines.svh
// Assertion macros used by the JSON string unescaper queue.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  // Result status codes
  localparam logic [3:0] ST_DATA     = 4'd0;
  localparam logic [3:0] ST_CLOSED   = 4'd1;
  localparam logic [3:0] ST_CONTROL  = 4'd2;
  localparam logic [3:0] ST_BADUTF8  = 4'd3;
  localparam logic [3:0] ST_BADESC   = 4'd4;
  localparam logic [3:0] ST_NONHEX   = 4'd5;
  localparam logic [3:0] ST_UNPAIRED = 4'd6;
  localparam logic [3:0] ST_LONELOW  = 4'd7;
  localparam logic [3:0] ST_ENDED    = 4'd8;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_ended;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] status;
    logic       run_last;
  } out_word_t;

  // All results caused by one input word; bytes[0] goes out first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic [3:0]      status;
  } burst_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- hw/rtl/jsu_front.sv -----
// ----------------------------------------------------------------------------
// jsu_front
// Scanner: takes one text word a cycle while the queue is not full, tracks
// escape and UTF-8 state and forms the burst of results that the word causes.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_word_t in_data,
  output logic     in_stall,
  input  qstat_t   q_stat,
  output logic     push,
  output burst_t   push_data
);

  typedef enum logic [6:0] {
    MODE_PLAIN   = 7'b0000001,
    MODE_UTF8    = 7'b0000010,
    MODE_ESCAPE  = 7'b0000100,
    MODE_HEX_HI  = 7'b0001000,
    MODE_WANT_BS = 7'b0010000,
    MODE_WANT_U  = 7'b0100000,
    MODE_HEX_LO  = 7'b1000000
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic burst_t encode(input logic [20:0] code);
    burst_t r;
    r = '0;
    r.status = ST_DATA;
    if (code < 21'h80) begin
      r.bytes[0] = code[7:0];
      r.last_idx = 2'd0;
    end else if (code < 21'h800) begin
      r.bytes[0] = {3'b110, code[10:6]};
      r.bytes[1] = {2'b10, code[5:0]};
      r.last_idx = 2'd1;
    end else if (code < 21'h10000) begin
      r.bytes[0] = {4'b1110, code[15:12]};
      r.bytes[1] = {2'b10, code[11:6]};
      r.bytes[2] = {2'b10, code[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = {5'b11110, code[20:18]};
      r.bytes[1] = {2'b10, code[17:12]};
      r.bytes[2] = {2'b10, code[11:6]};
      r.bytes[3] = {2'b10, code[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

  mode_t       mode_r, mode_nxt;
  logic [1:0]  need_r, need_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [23:0] held_r, held_nxt;
  logic [11:0] hex_r, hex_nxt;
  logic [9:0]  high_r, high_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [4:0]  hd;
  logic [15:0] hex_full;
  logic [20:0] u8_code;
  logic        u8_bad;
  burst_t      u8_burst;
  logic        res_valid;
  burst_t      res;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign b        = in_data.text_byte;
  assign hd       = hex_digit(b);
  assign hex_full = {hex_r, hd[3:0]};

  // Finished multibyte sequence: rebuild the code point and the raw bytes.
  always_comb begin
    u8_burst        = '0;
    u8_burst.status = ST_DATA;
    u8_code         = '0;
    u8_bad          = 1'b0;
    unique case (need_r)
      2'd1: begin
        u8_code           = {10'd0, held_r[4:0], b[5:0]};
        u8_bad            = u8_code < 21'h80;
        u8_burst.bytes[0] = held_r[7:0];
        u8_burst.bytes[1] = b;
        u8_burst.last_idx = 2'd1;
      end
      2'd2: begin
        u8_code           = {5'd0, held_r[11:8], held_r[5:0], b[5:0]};
        u8_bad            = u8_code < 21'h800 ||
                            (u8_code >= 21'hD800 && u8_code <= 21'hDFFF);
        u8_burst.bytes[0] = held_r[15:8];
        u8_burst.bytes[1] = held_r[7:0];
        u8_burst.bytes[2] = b;
        u8_burst.last_idx = 2'd2;
      end
      2'd3: begin
        u8_code           = {held_r[18:16], held_r[13:8], held_r[5:0], b[5:0]};
        u8_bad            = u8_code < 21'h10000 || u8_code > 21'h10FFFF;
        u8_burst.bytes[0] = held_r[23:16];
        u8_burst.bytes[1] = held_r[15:8];
        u8_burst.bytes[2] = held_r[7:0];
        u8_burst.bytes[3] = b;
        u8_burst.last_idx = 2'd3;
      end
      default: u8_bad = 1'b1;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    need_nxt   = need_r;
    seen_nxt   = seen_r;
    hcnt_nxt   = hcnt_r;
    held_nxt   = held_r;
    hex_nxt    = hex_r;
    high_nxt   = high_r;
    res_valid  = 1'b0;
    res        = '0;
    res.status = ST_DATA;

    if (in_data.text_ended) begin
      res_valid = 1'b1;
      mode_nxt  = MODE_PLAIN;
      priority case (1'b1)
        mode_r == MODE_UTF8:                             res.status = ST_BADUTF8;
        mode_r == MODE_WANT_BS || mode_r == MODE_WANT_U: res.status = ST_UNPAIRED;
        default:                                         res.status = ST_ENDED;
      endcase
    end else begin
      unique case (mode_r)
        MODE_UTF8: begin
          if (b[7:6] != 2'b10) begin
            res_valid  = 1'b1;
            res.status = ST_BADUTF8;
            mode_nxt   = MODE_PLAIN;
          end else if (seen_r + 2'd1 == need_r) begin
            res_valid = 1'b1;
            mode_nxt  = MODE_PLAIN;
            if (u8_bad) res.status = ST_BADUTF8;
            else        res        = u8_burst;
          end else begin
            held_nxt = {held_r[15:0], b};
            seen_nxt = seen_r + 2'd1;
          end
        end
        MODE_ESCAPE: begin
          res_valid = 1'b1;
          mode_nxt  = MODE_PLAIN;
          unique case (b)
            CH_QUOTE, CH_BSL, CH_SLASH: res.bytes[0] = b;
            CH_B: res.bytes[0] = 8'h08;
            CH_F: res.bytes[0] = 8'h0C;
            CH_N: res.bytes[0] = 8'h0A;
            CH_R: res.bytes[0] = 8'h0D;
            CH_T: res.bytes[0] = 8'h09;
            CH_U: begin
              res_valid = 1'b0;
              hcnt_nxt  = 2'd0;
              hex_nxt   = '0;
              mode_nxt  = MODE_HEX_HI;
            end
            default: res.status = ST_BADESC;
          endcase
        end
        MODE_HEX_HI, MODE_HEX_LO: begin
          if (!hd[4]) begin
            res_valid  = 1'b1;
            res.status = ST_NONHEX;
            mode_nxt   = MODE_PLAIN;
          end else if (hcnt_r != 2'd3) begin
            hex_nxt  = hex_full[11:0];
            hcnt_nxt = hcnt_r + 2'd1;
          end else if (mode_r == MODE_HEX_HI) begin
            if (hex_full >= 16'hD800 && hex_full <= 16'hDBFF) begin
              high_nxt = hex_full[9:0];
              hex_nxt  = '0;
              hcnt_nxt = 2'd0;
              mode_nxt = MODE_WANT_BS;
            end else if (hex_full >= 16'hDC00 && hex_full <= 16'hDFFF) begin
              res_valid  = 1'b1;
              res.status = ST_LONELOW;
              mode_nxt   = MODE_PLAIN;
            end else begin
              res_valid = 1'b1;
              res       = encode({5'd0, hex_full});
              mode_nxt  = MODE_PLAIN;
            end
          end else begin
            res_valid = 1'b1;
            mode_nxt  = MODE_PLAIN;
            if (hex_full < 16'hDC00 || hex_full > 16'hDFFF) res.status = ST_UNPAIRED;
            else res = encode(21'h10000 + {1'b0, high_r, hex_full[9:0]});
          end
        end
        MODE_WANT_BS: begin
          if (b == CH_BSL) begin
            mode_nxt = MODE_WANT_U;
          end else begin
            res_valid  = 1'b1;
            res.status = ST_UNPAIRED;
            mode_nxt   = MODE_PLAIN;
          end
        end
        MODE_WANT_U: begin
          if (b == CH_U) begin
            mode_nxt = MODE_HEX_LO;
          end else begin
            res_valid  = 1'b1;
            res.status = ST_UNPAIRED;
            mode_nxt   = MODE_PLAIN;
          end
        end
        default: begin
          mode_nxt = MODE_PLAIN;
          priority if (b == CH_QUOTE) begin
            res_valid  = 1'b1;
            res.status = ST_CLOSED;
          end else if (b < 8'h20) begin
            res_valid  = 1'b1;
            res.status = ST_CONTROL;
          end else if (b == CH_BSL) begin
            mode_nxt = MODE_ESCAPE;
          end else if (b < 8'h80) begin
            res_valid    = 1'b1;
            res.bytes[0] = b;
          end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            need_nxt = b[5] ? (b[4] ? 2'd3 : 2'd2) : 2'd1;
            held_nxt = {16'd0, b};
            seen_nxt = 2'd0;
            mode_nxt = MODE_UTF8;
          end else begin
            res_valid  = 1'b1;
            res.status = ST_BADUTF8;
          end
        end
      endcase
    end
  end

  assign push      = accept && res_valid;
  assign push_data = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      need_r <= '0;
      seen_r <= '0;
      hcnt_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      need_r <= need_nxt;
      seen_r <= seen_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
      hex_r  <= hex_nxt;
      high_r <= high_nxt;
    end
  end

endmodule

// ----- hw/rtl/jsu_queue.sv -----
// ----------------------------------------------------------------------------
// jsu_queue
// Short FIFO of result bursts between the scanner and the output stage.
// ----------------------------------------------------------------------------
`include "json_string_unescaper_top_defines.svh"

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  burst_t push_data,
  input  logic   pop,
  output burst_t head,
  output qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  burst_t             entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign stat.full  = count_r == CNT_W'(DEPTH);
  assign stat.empty = count_r == '0;
  assign head       = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_data;
  end

  `JSU_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !stat.full, "burst pushed into full queue")
  `JSU_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !stat.empty, "burst popped from empty queue")
  `JSU_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1, "queue count did not advance on push")
  `JSU_ASSERT_NOW(a_ptr_match, clk, rst_n, stat.empty || stat.full, wr_ptr_r == rd_ptr_r, "queue pointers disagree with count")

endmodule

// ----- hw/rtl/jsu_back.sv -----
// ----------------------------------------------------------------------------
// jsu_back
// Output stage: holds one burst; sends its words one per cycle unless stalled.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  qstat_t    q_stat,
  input  burst_t    head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  burst_t     cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       at_last;
  logic       sent;

  assign at_last = idx_r == cur_r.last_idx;
  assign sent    = cur_valid_r && !out_stall;
  assign pop     = !q_stat.empty && (!cur_valid_r || (sent && at_last));

  assign out_valid         = cur_valid_r;
  assign out_data.out_byte = cur_r.bytes[idx_r];
  assign out_data.status   = cur_r.status;
  assign out_data.run_last = at_last;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (sent) begin
      if (at_last) cur_valid_nxt = 1'b0;
      else         idx_nxt       = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
  end

endmodule

// ----- hw/rtl/json_string_unescaper_top.sv -----
// ----------------------------------------------------------------------------
// json_string_unescaper_top
// Unescapes a JSON string body into checked UTF-8 bytes.
// Input words carry one body byte (or an end-of-text flag) starting after the
// opening quote; output words carry one data byte or one final status, with
// run_last marking the last word caused by an input word. Both channels use
// valid/stall; a word moves when valid is high and stall is low.
// Throughput: one input word per cycle, one output word per cycle, while
// neither side stalls. An input word causes 0 to 4 output words, so the
// output side sets the pace while multibyte code points drain; the burst
// queue (QUEUE_DEPTH entries) soaks up the difference. With the queue and
// output stage idle, a taken input word's burst is written into the queue and
// then loaded into the output stage, which raises out_valid for its first
// result. When the receiver stalls, the queue fills and in_stall rises once it
// holds QUEUE_DEPTH bursts. Reset (rst_n low, synchronous) empties the queue
// and returns the scanner to plain content mode; after a done or error status
// the scanner returns to that mode by itself.
// ----------------------------------------------------------------------------
module json_string_unescaper_top
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_word_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  // Burst handoff between scanner, queue and output stage
  logic   push;
  burst_t push_data;
  logic   pop;
  burst_t head;
  qstat_t q_stat;

  // Classify each word and build its result burst
  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Hold bursts so either side can stall on its own
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Drain one burst at a time, one result word per cycle while not stalled
  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
